FILE: design/sstf_pkg.sv
// Package for the shortest-seek-time-first request scheduler.
// Holds field widths, batch and track constants, the sequencer state type
// and the control struct of the nearest-entry search unit. No dependencies.
package sstf_pkg;

  localparam int TRACK_W = 7;
  localparam int ENTRY_W = 6;
  localparam int POS_W   = 6;
  localparam int DELAY_W = 7;
  localparam int SEEK_W  = 7;
  localparam int SUM_W   = 13;

  localparam int MAX_BATCH_DEF = 64;
  localparam int TRACK_COUNT   = 128;
  localparam int TRACK_MAX     = TRACK_COUNT - 1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } st_t;

  // Control of the search unit for one scan pass.
  typedef struct packed {
    logic clear;   // start a new pass, forget the current best
    logic sample;  // present candidate is eligible this cycle
  } scan_ctl_t;

endpackage

FILE: design/sstf_if.sv
// Channel interfaces of the scheduler: the request channel and the result channel.
// Depends on sstf_pkg for the field widths.
interface sstf_req_if;
  logic                         valid;
  logic                         ready;
  logic [sstf_pkg::TRACK_W-1:0] track;
  logic                         last;

  modport source (output valid, output track, output last, input ready);
  modport sink   (input valid, input track, input last, output ready);
endinterface

interface sstf_res_if;
  logic                                valid;
  logic                                ready;
  logic        [sstf_pkg::ENTRY_W-1:0] entry_index;
  logic        [sstf_pkg::TRACK_W-1:0] served_track;
  logic        [sstf_pkg::POS_W-1:0]   service_position;
  logic signed [sstf_pkg::DELAY_W-1:0] delay;
  logic        [sstf_pkg::SEEK_W-1:0]  seek_distance;
  logic        [sstf_pkg::SUM_W-1:0]   head_travel;
  logic                                final_res;

  modport source (output valid, output entry_index, output served_track,
                  output service_position, output delay, output seek_distance,
                  output head_travel, output final_res, input ready);
  modport sink   (input valid, input entry_index, input served_track,
                  input service_position, input delay, input seek_distance,
                  input head_travel, input final_res, output ready);
endinterface

FILE: design/sstf_request_scheduler.sv
// Top level of the shortest-seek-time-first request scheduler.
// Depends on sstf_pkg, the channel interfaces in sstf_if and the search unit sstf_nearest.
//
//   channel   | dir | payload                                            | accept
//   ----------+-----+----------------------------------------------------+-------------
//   in_req    | in  | track, last                                        | valid & ready
//   out_res   | out | entry_index, served_track, service_position,       | valid & ready
//             |     | delay, seek_distance, head_travel, final_res       |
//
// The block takes requests while it is loading. After the request
// that carries last, the block emits n results (n requests stored in the batch);
// for each result it scans every stored entry, serves the nearest eligible one
// and holds the result on the output until it is taken. The scan reads one
// stored track per cycle through the single read port of the track memory, and
// that port limits the scan. Reset is synchronous and active low; it returns the
// sequencer to loading with an empty batch. A stall on the result channel holds
// the result register and pauses the sequencer; no request is taken until the
// last result of the batch has been delivered.
module sstf_request_scheduler #(
  parameter int MAX_BATCH = sstf_pkg::MAX_BATCH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sstf_req_if.sink    in_req,
  sstf_res_if.source  out_res
);

  localparam int IDX_W = $clog2(MAX_BATCH);
  localparam int CNT_W = $clog2(MAX_BATCH + 1);
  localparam int TW    = sstf_pkg::TRACK_W;
  localparam int EW    = sstf_pkg::ENTRY_W;
  localparam int PW    = sstf_pkg::POS_W;
  localparam int DW    = sstf_pkg::DELAY_W;
  localparam int SW    = sstf_pkg::SEEK_W;
  localparam int MW    = sstf_pkg::SUM_W;

  // Track memory: written while loading, read one entry per cycle while scanning.
  logic [TW-1:0] mem [MAX_BATCH];
  logic [TW-1:0] rd_trk_r;
  logic [IDX_W-1:0] rd_addr;
  logic          wr_en;
  logic [TW-1:0] trk_sat;

  sstf_pkg::st_t state_r, state_nxt;

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;       // requests stored in this batch
  logic [CNT_W-1:0]     iss_r, iss_nxt;       // next entry to read in the scan
  logic                 pend_r, pend_nxt;     // read data of entry pidx_r is in rd_trk_r
  logic [IDX_W-1:0]     pidx_r, pidx_nxt;
  logic [IDX_W-1:0]     k_r, k_nxt;           // service position being worked on
  logic [MAX_BATCH-1:0] marks_r, marks_nxt;   // served marks
  logic [TW-1:0]        head_r, head_nxt;
  logic [MW-1:0]        sum_r, sum_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [EW-1:0]        o_idx_r, o_idx_nxt;
  logic [TW-1:0]        o_trk_r, o_trk_nxt;
  logic [PW-1:0]        o_pos_r, o_pos_nxt;
  logic signed [DW-1:0] o_dly_r, o_dly_nxt;
  logic [SW-1:0]        o_seek_r, o_seek_nxt;
  logic [MW-1:0]        o_sum_r, o_sum_nxt;
  logic                 o_fin_r, o_fin_nxt;

  sstf_pkg::scan_ctl_t ctl;
  logic [IDX_W-1:0]    best_idx;
  logic [TW-1:0]       best_trk;
  logic [TW-1:0]       best_dist;

  logic          in_fire;
  logic          full;
  logic          eligible;
  logic          is_final;
  logic [TW-1:0] seek;
  logic [MW:0]   sum_wide;

  assign in_fire = in_req.valid && in_req.ready;
  assign full    = (cnt_r == CNT_W'(MAX_BATCH));
  assign wr_en   = in_fire && !full;

  // Tracks beyond the last valid track are clamped on the way into the store.
  assign trk_sat = (int'(in_req.track) > sstf_pkg::TRACK_MAX)
                 ? TW'(sstf_pkg::TRACK_MAX) : in_req.track;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[IDX_W-1:0]] <= trk_sat;
    end
  end

  always_ff @(posedge clk) begin
    rd_trk_r <= mem[rd_addr];
  end

  // The first service step considers only entry zero; later steps consider every
  // entry that has not been served yet.
  assign eligible = (k_r == '0) ? (pidx_r == '0) : !marks_r[pidx_r];
  assign is_final = (CNT_W'(k_r) == (cnt_r - CNT_W'(1)));
  assign seek     = (k_r == '0) ? '0 : best_dist;
  assign sum_wide = {1'b0, sum_r} + (MW + 1)'(seek);

  sstf_nearest #(
    .IDX_W (IDX_W)
  ) u_nearest (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .cand_idx  (pidx_r),
    .cand_trk  (rd_trk_r),
    .head      (head_r),
    .best_idx  (best_idx),
    .best_trk  (best_trk),
    .best_dist (best_dist)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    k_nxt         = k_r;
    marks_nxt     = marks_r;
    head_nxt      = head_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    o_idx_nxt     = o_idx_r;
    o_trk_nxt     = o_trk_r;
    o_pos_nxt     = o_pos_r;
    o_dly_nxt     = o_dly_r;
    o_seek_nxt    = o_seek_r;
    o_sum_nxt     = o_sum_r;
    o_fin_nxt     = o_fin_r;
    rd_addr       = iss_r[IDX_W-1:0];
    ctl.clear     = 1'b0;
    ctl.sample    = 1'b0;
    in_req.ready  = 1'b0;

    unique case (state_r)
      sstf_pkg::ST_LOAD: begin
        in_req.ready = 1'b1;
        if (in_fire) begin
          if (!full) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (in_req.last) begin
            state_nxt = sstf_pkg::ST_SCAN;
            marks_nxt = '0;
            sum_nxt   = '0;
            k_nxt     = '0;
            iss_nxt   = '0;
            ctl.clear = 1'b1;
          end
        end
      end

      sstf_pkg::ST_SCAN: begin
        ctl.sample = pend_r && eligible;
        if (iss_r < cnt_r) begin
          iss_nxt  = iss_r + CNT_W'(1);
          pend_nxt = 1'b1;
          pidx_nxt = iss_r[IDX_W-1:0];
        end else if (!pend_r) begin
          // Scan complete: serve the best candidate and present the result.
          marks_nxt[best_idx] = 1'b1;
          head_nxt      = best_trk;
          sum_nxt       = sum_wide[MW] ? '1 : sum_wide[MW-1:0];
          out_valid_nxt = 1'b1;
          o_idx_nxt     = EW'(best_idx);
          o_trk_nxt     = best_trk;
          o_pos_nxt     = PW'(k_r);
          o_dly_nxt     = DW'(k_r) - DW'(best_idx);
          o_seek_nxt    = SW'(seek);
          o_sum_nxt     = sum_wide[MW] ? '1 : sum_wide[MW-1:0];
          o_fin_nxt     = is_final;
          state_nxt     = sstf_pkg::ST_EMIT;
        end
      end

      sstf_pkg::ST_EMIT: begin
        if (out_res.ready) begin
          out_valid_nxt = 1'b0;
          if (o_fin_r) begin
            state_nxt = sstf_pkg::ST_LOAD;
            marks_nxt = '0;
            cnt_nxt   = '0;
          end else begin
            state_nxt = sstf_pkg::ST_SCAN;
            k_nxt     = k_r + IDX_W'(1);
            iss_nxt   = '0;
            ctl.clear = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = sstf_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sstf_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      iss_r       <= '0;
      pend_r      <= 1'b0;
      k_r         <= '0;
      marks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      k_r         <= k_nxt;
      marks_r     <= marks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r   <= pidx_nxt;
    head_r   <= head_nxt;
    sum_r    <= sum_nxt;
    o_idx_r  <= o_idx_nxt;
    o_trk_r  <= o_trk_nxt;
    o_pos_r  <= o_pos_nxt;
    o_dly_r  <= o_dly_nxt;
    o_seek_r <= o_seek_nxt;
    o_sum_r  <= o_sum_nxt;
    o_fin_r  <= o_fin_nxt;
  end

  assign out_res.valid            = out_valid_r;
  assign out_res.entry_index      = o_idx_r;
  assign out_res.served_track     = o_trk_r;
  assign out_res.service_position = o_pos_r;
  assign out_res.delay            = o_dly_r;
  assign out_res.seek_distance    = o_seek_r;
  assign out_res.head_travel      = o_sum_r;
  assign out_res.final_res        = o_fin_r;

endmodule

FILE: design/sstf_nearest.sv
// Shared search unit: one distance and compare per cycle, keeps the best candidate.
// Depends on sstf_pkg for the track width and the control struct.
module sstf_nearest #(
  parameter int IDX_W = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sstf_pkg::scan_ctl_t          ctl,
  input  logic [IDX_W-1:0]             cand_idx,
  input  logic [sstf_pkg::TRACK_W-1:0] cand_trk,
  input  logic [sstf_pkg::TRACK_W-1:0] head,
  output logic [IDX_W-1:0]             best_idx,
  output logic [sstf_pkg::TRACK_W-1:0] best_trk,
  output logic [sstf_pkg::TRACK_W-1:0] best_dist
);

  logic                         found_r;
  logic [IDX_W-1:0]             best_idx_r;
  logic [sstf_pkg::TRACK_W-1:0] best_trk_r;
  logic [sstf_pkg::TRACK_W-1:0] best_dist_r;
  logic [sstf_pkg::TRACK_W-1:0] cand_dist;
  logic                         take;

  assign cand_dist = (cand_trk > head) ? (cand_trk - head) : (head - cand_trk);
  // Strict compare: scanning in ascending index order keeps the lowest index on a tie.
  assign take = ctl.sample && (!found_r || (cand_dist < best_dist_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctl.clear) begin
      best_idx_r  <= cand_idx;
      best_trk_r  <= cand_trk;
      best_dist_r <= cand_dist;
    end
  end

  assign best_idx  = best_idx_r;
  assign best_trk  = best_trk_r;
  assign best_dist = best_dist_r;

endmodule

FILE: design/sstf_sva_checker.sv
// Port-level checker for the scheduler, with the bind that attaches it.
// Depends on sstf_pkg for field widths and on the top level sstf_request_scheduler.
module sstf_sva_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sstf_pkg::POS_W-1:0]  out_service_position,
  input logic [sstf_pkg::SEEK_W-1:0] out_seek_distance,
  input logic                        out_final_res
);

  // A result that is offered stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn before it was taken");

  // No request is taken while a result is pending.
  a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request channel ready while a result is pending");

  // The request that closes a batch stops further loading.
  a_last_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("request taken right after the end of a batch");

  // Delivering the final result of a batch reopens the request channel.
  a_final_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_final_res) |=> in_ready)
    else $error("request channel not ready after the last result");

  // The first request served in a batch always reports a seek distance of zero.
  a_first_no_seek: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_service_position == '0)) |-> (out_seek_distance == '0))
    else $error("first result of a batch shows a seek distance");

endmodule

bind sstf_request_scheduler sstf_sva_checker u_sstf_sva_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_req.valid),
  .in_ready             (in_req.ready),
  .in_last              (in_req.last),
  .out_valid            (out_res.valid),
  .out_ready            (out_res.ready),
  .out_service_position (out_res.service_position),
  .out_seek_distance    (out_res.seek_distance),
  .out_final_res        (out_res.final_res)
);
